/* rtl/core/sparse_polynomial_add_merge_macros.svh */
// Assertion macros shared by the sparse polynomial adder RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_MACROS_SVH

// same-cycle implication
`define SPADD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPADD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/spadd_pkg.sv */
// Shared types and constants of the sparse polynomial adder.
// Used by every module under rtl/core but spadd_ram; depends on nothing.
package spadd_pkg;

   localparam int TERMS_PER_LIST = 32;
   localparam int ADDR_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
   localparam int CNT_W = $clog2(TERMS_PER_LIST + 1);

   localparam int OP_W = 2;
   localparam int COEFF_W = 16;
   localparam int EXPO_W = 16;
   localparam int SUM_W = COEFF_W + 1;
   localparam int TERM_W = COEFF_W + EXPO_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD_A,
      CMD_LOAD_B,
      CMD_MERGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic signed [COEFF_W-1:0] coeff;
      logic [EXPO_W-1:0] expo;
   } cmd_type;

   // push side and pop side of the command queue
   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } queue_push_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } back_state_type;

endpackage

/* rtl/core/spadd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the term lists of the sparse polynomial adder.
module spadd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/spadd_front.sv */
// Front end: takes commands off the request port and classifies them.
// Depends on spadd_pkg; feeds spadd_queue.
module spadd_front (
   input  logic                                 start,
   output logic                                 busy,
   input  logic [spadd_pkg::OP_W-1:0]           req_op,
   input  logic signed [spadd_pkg::COEFF_W-1:0] req_coeff_in,
   input  logic [spadd_pkg::EXPO_W-1:0]         req_expo_in,
   input  logic                                 queue_full,
   output spadd_pkg::queue_push_type            push
);

   logic accept;

   assign busy = queue_full;
   assign accept = start && !queue_full;

   always_comb begin
      push.valid = 1'b0;
      push.cmd.kind = spadd_pkg::CMD_MERGE;
      push.cmd.coeff = req_coeff_in;
      push.cmd.expo = req_expo_in;
      unique case (req_op)
         spadd_pkg::OP_LOAD_A: begin
            push.valid = accept;
            push.cmd.kind = spadd_pkg::CMD_LOAD_A;
         end
         spadd_pkg::OP_LOAD_B: begin
            push.valid = accept;
            push.cmd.kind = spadd_pkg::CMD_LOAD_B;
         end
         spadd_pkg::OP_MERGE: begin
            push.valid = accept;
            push.cmd.kind = spadd_pkg::CMD_MERGE;
         end
         // undefined op: take the word, drop it
         default: begin
            push.valid = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/core/spadd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on spadd_pkg and the assertion macro header.
`include "sparse_polynomial_add_merge_macros.svh"

module spadd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  spadd_pkg::queue_push_type push,
   input  logic                      pop,
   output spadd_pkg::queue_head_type head,
   output logic                      full
);

   spadd_pkg::cmd_type              slot_ff [spadd_pkg::QUEUE_DEPTH];
   logic [spadd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [spadd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [spadd_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                            do_push, do_pop;

   assign full = (count_ff == spadd_pkg::QCNT_W'(spadd_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == spadd_pkg::QPTR_W'(spadd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + spadd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == spadd_pkg::QPTR_W'(spadd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + spadd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + spadd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - spadd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   `SPADD_ASSERT_SAME(a_queue_push_has_room, clock, reset, push.valid, !full, "push into full queue")
   `SPADD_ASSERT_NEXT(a_queue_push_counts, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + spadd_pkg::QCNT_W'(1), "queue count lost a push")

endmodule

/* rtl/core/spadd_back.sv */
// Back end: executes loads into the term RAMs and runs the two-way merge.
// Depends on spadd_pkg, spadd_ram and the assertion macro header.
`include "sparse_polynomial_add_merge_macros.svh"

module spadd_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spadd_pkg::queue_head_type             head,
   output logic                                  pop,
   output logic                                  rsp_strobe,
   output logic signed [spadd_pkg::SUM_W-1:0]    rsp_sum_coeff,
   output logic [spadd_pkg::EXPO_W-1:0]          rsp_sum_expo,
   output logic                                  rsp_last
);

   spadd_pkg::back_state_type state_ff, state_in;
   logic [spadd_pkg::CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [spadd_pkg::CNT_W-1:0] i_ff, i_in, j_ff, j_in;

   logic                                 strobe_ff, strobe_in;
   logic signed [spadd_pkg::SUM_W-1:0]   coeff_ff, coeff_in;
   logic [spadd_pkg::EXPO_W-1:0]         expo_ff, expo_in;
   logic                                 last_ff, last_in;

   logic                                 wa_en, wb_en;
   logic [spadd_pkg::TERM_W-1:0]         wr_term, rd_a, rd_b;

   logic signed [spadd_pkg::COEFF_W-1:0] ca, cb;
   logic [spadd_pkg::EXPO_W-1:0]         ea, eb;
   logic                                 have_a, have_b, take_a, take_b;

   assign wr_term = {head.cmd.coeff, head.cmd.expo};

   spadd_ram #(
      .WIDTH (spadd_pkg::TERM_W),
      .DEPTH (spadd_pkg::TERMS_PER_LIST)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wa_en),
      .wr_addr (cnt_a_ff[spadd_pkg::ADDR_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (i_in[spadd_pkg::ADDR_W-1:0]),
      .rd_data (rd_a)
   );

   spadd_ram #(
      .WIDTH (spadd_pkg::TERM_W),
      .DEPTH (spadd_pkg::TERMS_PER_LIST)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (cnt_b_ff[spadd_pkg::ADDR_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (j_in[spadd_pkg::ADDR_W-1:0]),
      .rd_data (rd_b)
   );

   assign ca = rd_a[spadd_pkg::TERM_W-1 -: spadd_pkg::COEFF_W];
   assign cb = rd_b[spadd_pkg::TERM_W-1 -: spadd_pkg::COEFF_W];
   assign ea = rd_a[spadd_pkg::EXPO_W-1:0];
   assign eb = rd_b[spadd_pkg::EXPO_W-1:0];
   assign have_a = (i_ff < cnt_a_ff);
   assign have_b = (j_ff < cnt_b_ff);

   // pick the head with the larger exponent, both on a tie
   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (have_a && have_b) begin
         if (ea > eb) begin
            take_a = 1'b1;
         end else if (ea < eb) begin
            take_b = 1'b1;
         end else begin
            take_a = 1'b1;
            take_b = 1'b1;
         end
      end else if (have_a) begin
         take_a = 1'b1;
      end else begin
         take_b = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      i_in = i_ff;
      j_in = j_ff;
      pop = 1'b0;
      wa_en = 1'b0;
      wb_en = 1'b0;
      strobe_in = 1'b0;
      coeff_in = coeff_ff;
      expo_in = expo_ff;
      last_in = last_ff;
      unique case (state_ff)
         spadd_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.cmd.kind)
                  spadd_pkg::CMD_LOAD_A: begin
                     // drop the word when the list is full
                     if (cnt_a_ff < spadd_pkg::CNT_W'(spadd_pkg::TERMS_PER_LIST)) begin
                        wa_en = 1'b1;
                        cnt_a_in = cnt_a_ff + spadd_pkg::CNT_W'(1);
                     end
                  end
                  spadd_pkg::CMD_LOAD_B: begin
                     if (cnt_b_ff < spadd_pkg::CNT_W'(spadd_pkg::TERMS_PER_LIST)) begin
                        wb_en = 1'b1;
                        cnt_b_in = cnt_b_ff + spadd_pkg::CNT_W'(1);
                     end
                  end
                  spadd_pkg::CMD_MERGE: begin
                     // both heads are read this cycle; two empty lists emit nothing
                     i_in = '0;
                     j_in = '0;
                     if (cnt_a_ff != '0 || cnt_b_ff != '0) begin
                        state_in = spadd_pkg::ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spadd_pkg::ST_MERGE: begin
            strobe_in = 1'b1;
            expo_in = take_a ? ea : eb;
            if (take_a && take_b) begin
               coeff_in = spadd_pkg::SUM_W'(ca) + spadd_pkg::SUM_W'(cb);
            end else if (take_a) begin
               coeff_in = spadd_pkg::SUM_W'(ca);
            end else begin
               coeff_in = spadd_pkg::SUM_W'(cb);
            end
            i_in = i_ff + spadd_pkg::CNT_W'(take_a);
            j_in = j_ff + spadd_pkg::CNT_W'(take_b);
            last_in = (i_in >= cnt_a_ff) && (j_in >= cnt_b_ff);
            if (last_in) begin
               state_in = spadd_pkg::ST_IDLE;
               cnt_a_in = '0;
               cnt_b_in = '0;
            end
         end
         default: begin
            state_in = spadd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spadd_pkg::ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         i_ff <= i_in;
         j_ff <= j_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      coeff_ff <= coeff_in;
      expo_ff <= expo_in;
      last_ff <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_sum_coeff = coeff_ff;
   assign rsp_sum_expo = expo_ff;
   assign rsp_last = last_ff;

   `SPADD_ASSERT_SAME(a_back_strobe_from_merge, clock, reset, strobe_ff, $past(state_ff) == spadd_pkg::ST_MERGE, "result word outside a merge")
   `SPADD_ASSERT_SAME(a_back_last_ends_merge, clock, reset, strobe_ff && last_ff, state_ff == spadd_pkg::ST_IDLE && cnt_a_ff == '0 && cnt_b_ff == '0, "merge still running after last word")
   `SPADD_ASSERT_SAME(a_back_index_bounds, clock, reset, state_ff == spadd_pkg::ST_MERGE, (i_ff <= cnt_a_ff) && (j_ff <= cnt_b_ff) && (have_a || have_b), "merge index past list end")

endmodule

/* rtl/core/sparse_polynomial_add_merge.sv */
// Sparse polynomial adder: two term lists and a two-way merge of them.
//
// Request channel: a command word is taken at a rising edge with start high
// and busy low. req_op selects load into list A, load into list B or merge;
// req_coeff_in and req_expo_in carry the term of a load. Op code 3 is taken
// and dropped, as is a load into a list that already holds all its terms.
// Commands pass a two-entry queue to the back end, so busy rises only while
// that queue is full, which happens when commands arrive during a merge.
// Loads retire at one per cycle while no merge runs. A merge command is
// written into the queue and popped by the idle back end, which addresses
// both list heads; the term RAMs register them, the merge state picks the
// larger exponent and the result word is registered onto the result port.
// A merge emits one term per cycle, at most na + nb for lists of na and nb
// terms. Two empty lists emit no word. A merge empties both lists.
// Result channel: rsp_strobe marks each word for exactly one cycle, rsp_last
// marks the final term. The receiver cannot stall it.
// Reset empties the queue and both lists; list contents are not cleared.
// Depends on spadd_pkg, spadd_front, spadd_queue, spadd_back, spadd_ram.
module sparse_polynomial_add_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [spadd_pkg::OP_W-1:0]           req_op,
   input  logic signed [spadd_pkg::COEFF_W-1:0] req_coeff_in,
   input  logic [spadd_pkg::EXPO_W-1:0]         req_expo_in,
   output logic                                 rsp_strobe,
   output logic signed [spadd_pkg::SUM_W-1:0]   rsp_sum_coeff,
   output logic [spadd_pkg::EXPO_W-1:0]         rsp_sum_expo,
   output logic                                 rsp_last
);

   spadd_pkg::queue_push_type push;
   spadd_pkg::queue_head_type head;
   logic                      queue_full;
   logic                      pop;

   spadd_front u_front (
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_coeff_in (req_coeff_in),
      .req_expo_in  (req_expo_in),
      .queue_full   (queue_full),
      .push         (push)
   );

   spadd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   spadd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_sum_coeff (rsp_sum_coeff),
      .rsp_sum_expo  (rsp_sum_expo),
      .rsp_last      (rsp_last)
   );

endmodule
